// ----- design/occupancy_grid_ray_update_defines.svh -----
// ---------------------------------------------------------------------------
// Occupancy grid ray update: assertion macros
// Shared concurrent assertion forms, clocked on clk, disabled in reset.
// ---------------------------------------------------------------------------
`ifndef OCCUPANCY_GRID_RAY_UPDATE_DEFINES_SVH
`define OCCUPANCY_GRID_RAY_UPDATE_DEFINES_SVH

// same-cycle implication
`define OGRU_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ogru assertion failed");

// next-cycle implication
`define OGRU_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ogru assertion failed");

`endif

// ----- design/ogru_pkg.sv -----
// ---------------------------------------------------------------------------
// Occupancy grid ray update: package
// Codes, grid sizes, sequencer states and the grid bounds check.
// ---------------------------------------------------------------------------
package ogru_pkg;

    localparam int MAX_COLUMNS = 256;
    localparam int MAX_ROWS    = 256;
    localparam int COL_W       = $clog2(MAX_COLUMNS);
    localparam int ROW_W       = $clog2(MAX_ROWS);
    localparam int ADDR_W      = COL_W + ROW_W;
    localparam int CELLS       = MAX_COLUMNS * MAX_ROWS;

    localparam logic [1:0] ACT_POINT = 2'd0;
    localparam logic [1:0] ACT_READ  = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    localparam logic [2:0] STATUS_ACCEPTED     = 3'd0;
    localparam logic [2:0] STATUS_RANGE        = 3'd1;
    localparam logic [2:0] STATUS_OUTSIDE      = 3'd2;
    localparam logic [2:0] STATUS_ROBOT_OUT    = 3'd3;
    localparam logic [2:0] STATUS_READ         = 3'd4;
    localparam logic [2:0] STATUS_CLEARED      = 3'd5;

    localparam logic [1:0] CELL_UNKNOWN = 2'd0;
    localparam logic [1:0] CELL_FREE    = 2'd1;
    localparam logic [1:0] CELL_OCC     = 2'd2;

    localparam logic [2:0] REG_ORIGIN_X  = 3'd0;
    localparam logic [2:0] REG_ORIGIN_Y  = 3'd1;
    localparam logic [2:0] REG_INV_RES   = 3'd2;
    localparam logic [2:0] REG_COLUMNS   = 3'd3;
    localparam logic [2:0] REG_ROWS      = 3'd4;
    localparam logic [2:0] REG_MIN_Z     = 3'd5;
    localparam logic [2:0] REG_MAX_Z     = 3'd6;
    localparam logic [2:0] REG_RANGE_SQ  = 3'd7;

    typedef logic signed [27:0] pos_t;

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_POSE_X,
        S_POSE_Y,
        S_POSE_CHK,
        S_PFREE_RD,
        S_PFREE_WR,
        S_SQ_X,
        S_SQ_Y,
        S_SQ_CHK,
        S_ROT1,
        S_ROT2,
        S_ROT3,
        S_ROT4,
        S_ROT5,
        S_ROT6,
        S_ROT7,
        S_WALK_CHK,
        S_WALK_WR,
        S_END_RD,
        S_END_WR,
        S_READ_RD,
        S_READ_WAIT,
        S_DONE
    } state_t;

    function automatic logic in_grid(pos_t c, pos_t r, logic [8:0] cols, logic [8:0] rows);
        logic [8:0] ce;
        logic [8:0] re;
        ce = (cols > 9'(MAX_COLUMNS)) ? 9'(MAX_COLUMNS) : cols;
        re = (rows > 9'(MAX_ROWS)) ? 9'(MAX_ROWS) : rows;
        return (c >= 0) && (r >= 0) && (c < $signed({19'd0, ce})) && (r < $signed({19'd0, re}));
    endfunction

endpackage

// ----- design/ogru_ifs.sv -----
// ---------------------------------------------------------------------------
// Occupancy grid ray update: channel interfaces
// Valid/ready channels for command words and result words.
// ---------------------------------------------------------------------------
interface ogru_in_if;
    logic               valid;
    logic               ready;
    logic [1:0]         action;
    logic               scan_start;
    logic signed [23:0] robot_x;
    logic signed [23:0] robot_y;
    logic signed [15:0] cos_yaw;
    logic signed [15:0] sin_yaw;
    logic signed [23:0] point_x;
    logic signed [23:0] point_y;
    logic signed [23:0] point_z;
    logic [7:0]         read_column;
    logic [7:0]         read_row;

    modport source (output valid, action, scan_start, robot_x, robot_y, cos_yaw, sin_yaw,
                    point_x, point_y, point_z, read_column, read_row, input ready);
    modport sink (input valid, action, scan_start, robot_x, robot_y, cos_yaw, sin_yaw,
                  point_x, point_y, point_z, read_column, read_row, output ready);
endinterface

interface ogru_out_if;
    logic        valid;
    logic        ready;
    logic [2:0]  status;
    logic [1:0]  cell_state;
    logic [15:0] accepted_count;

    modport source (output valid, status, cell_state, accepted_count, input ready);
    modport sink (input valid, status, cell_state, accepted_count, output ready);
endinterface

// ----- design/occupancy_grid_ray_update.sv -----
// ---------------------------------------------------------------------------
// Occupancy grid ray update
// 256x256 grid of 2-bit cells updated by Bresenham rays from the robot cell.
// ---------------------------------------------------------------------------
// Usage:
//   pt_in carries one command word (integrate point, read cell, clear grid);
//   res_out returns exactly one result word per command, in order.
//   cfg_we/cfg_index/cfg_data write one register per cycle; write only idle.
// Sequencing (one multiplier shared under a sequencer, one grid RAM port):
//   read: one RAM lookup; a point is dropped with no pose, out of range or off grid;
//   scan start first maps the robot to its cell (dropped if the robot is outside the grid).
//   integrated point: each ray cell is checked and then written, then the endpoint.
//   clear: one RAM word per cycle.
// Throughput: one command at a time; pt_in.ready is high only when idle.
// Reset: grid is swept to unknown, pt_in.ready held low;
//   config writes are taken during the sweep.
// Stall: a finished result sits in an output register; the next command is
//   accepted meanwhile and its result waits until res_out drains.
// ---------------------------------------------------------------------------
`include "occupancy_grid_ray_update_defines.svh"

module occupancy_grid_ray_update (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_index,
    input  logic [47:0] cfg_data,
    ogru_in_if.sink     pt_in,
    ogru_out_if.source  res_out
);

    // config
    logic signed [23:0] origin_x_reg, origin_y_reg, min_z_reg, max_z_reg;
    logic [23:0]        inv_res_reg;
    logic [8:0]         cols_reg, rows_reg;
    logic [47:0]        range_reg;

    // captured command
    logic signed [23:0] rx_reg, ry_reg, px_reg, py_reg, pz_reg;
    logic signed [15:0] cs_reg, sn_reg;
    logic [7:0]         rd_col_reg, rd_row_reg;

    ogru_pkg::state_t state_reg, state_next;

    logic signed [27:0] mul_a;
    logic signed [24:0] mul_b;
    logic signed [52:0] prod_reg;
    logic signed [52:0] acc_reg, acc_next;

    ogru_pkg::pos_t pcol_reg, pcol_next, mx_reg, mx_next, my_reg, my_next;
    ogru_pkg::pos_t prod_cell;

    logic [7:0]  robot_col_reg, robot_col_next, robot_row_reg, robot_row_next;
    logic        pose_valid_reg, pose_valid_next;
    logic [15:0] scan_cnt_reg, scan_cnt_next;

    logic signed [10:0] cur_c_reg, cur_c_next, cur_r_reg, cur_r_next;
    logic signed [10:0] dc_reg, dc_next, dr_reg, dr_next, err_reg, err_next;
    logic               sc_reg, sc_next, sr_reg, sr_next;
    logic [7:0]         end_c_reg, end_c_next, end_r_reg, end_r_next;

    logic [2:0]  status_reg, status_next;
    logic [1:0]  cell_reg, cell_next;
    logic [15:0] clr_cnt_reg, clr_cnt_next;
    logic        clr_reply_reg, clr_reply_next;

    logic        out_valid_reg, out_valid_next;
    logic [2:0]  out_status_reg;
    logic [1:0]  out_cell_reg;
    logic [15:0] out_count_reg;
    logic        out_load;

    logic [1:0]                    grid_mem [ogru_pkg::CELLS];
    logic                          mem_we;
    logic [ogru_pkg::ADDR_W-1:0]   mem_addr;
    logic [1:0]                    mem_wdata;
    logic [1:0]                    mem_rdata_reg;

    logic signed [24:0] inv_b;
    logic signed [52:0] d2;
    logic signed [52:0] rot_sum;
    logic signed [10:0] ecs, ers, c0, r0, dcv, drv;
    logic signed [11:0] e2;
    logic               cur_in, in_band;
    logic [15:0]        cnt_inc;

    assign pt_in.ready            = (state_reg == ogru_pkg::S_IDLE);
    assign res_out.valid          = out_valid_reg;
    assign res_out.status         = out_status_reg;
    assign res_out.cell_state     = out_cell_reg;
    assign res_out.accepted_count = out_count_reg;

    assign inv_b     = $signed({1'b0, inv_res_reg});
    assign prod_cell = ogru_pkg::pos_t'(prod_reg >>> 26);
    assign d2        = acc_reg + prod_reg;
    assign rot_sum   = acc_reg + prod_reg;
    assign in_band   = (pz_reg >= min_z_reg) && (pz_reg <= max_z_reg);
    assign cnt_inc   = (scan_cnt_reg == 16'hFFFF) ? scan_cnt_reg : scan_cnt_reg + 16'd1;
    assign cur_in    = ogru_pkg::in_grid(ogru_pkg::pos_t'(cur_c_reg), ogru_pkg::pos_t'(cur_r_reg),
                                         cols_reg, rows_reg);

    // grid RAM
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            grid_mem[mem_addr] <= mem_wdata;
        end
        mem_rdata_reg <= grid_mem[mem_addr];
    end

    // shared multiplier
    always_ff @(posedge clk)
    begin
        prod_reg <= 53'(mul_a * mul_b);
    end

    // config registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            inv_res_reg  <= 24'd65536;
            cols_reg     <= 9'd256;
            rows_reg     <= 9'd256;
            min_z_reg    <= '0;
            max_z_reg    <= 24'sd2048;
            range_reg    <= 48'd104857600;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                ogru_pkg::REG_ORIGIN_X: origin_x_reg <= $signed(cfg_data[23:0]);
                ogru_pkg::REG_ORIGIN_Y: origin_y_reg <= $signed(cfg_data[23:0]);
                ogru_pkg::REG_INV_RES:  inv_res_reg  <= cfg_data[23:0];
                ogru_pkg::REG_COLUMNS:  cols_reg     <= cfg_data[8:0];
                ogru_pkg::REG_ROWS:     rows_reg     <= cfg_data[8:0];
                ogru_pkg::REG_MIN_Z:    min_z_reg    <= $signed(cfg_data[23:0]);
                ogru_pkg::REG_MAX_Z:    max_z_reg    <= $signed(cfg_data[23:0]);
                ogru_pkg::REG_RANGE_SQ: range_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ogru_pkg::S_CLEAR;
            clr_cnt_reg    <= '0;
            clr_reply_reg  <= 1'b0;
            pose_valid_reg <= 1'b0;
            robot_col_reg  <= '0;
            robot_row_reg  <= '0;
            scan_cnt_reg   <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            clr_reply_reg  <= clr_reply_next;
            pose_valid_reg <= pose_valid_next;
            robot_col_reg  <= robot_col_next;
            robot_row_reg  <= robot_row_next;
            scan_cnt_reg   <= scan_cnt_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        if (pt_in.valid && pt_in.ready)
        begin
            rx_reg     <= pt_in.robot_x;
            ry_reg     <= pt_in.robot_y;
            cs_reg     <= pt_in.cos_yaw;
            sn_reg     <= pt_in.sin_yaw;
            px_reg     <= pt_in.point_x;
            py_reg     <= pt_in.point_y;
            pz_reg     <= pt_in.point_z;
            rd_col_reg <= pt_in.read_column;
            rd_row_reg <= pt_in.read_row;
        end
        acc_reg    <= acc_next;
        pcol_reg   <= pcol_next;
        mx_reg     <= mx_next;
        my_reg     <= my_next;
        cur_c_reg  <= cur_c_next;
        cur_r_reg  <= cur_r_next;
        dc_reg     <= dc_next;
        dr_reg     <= dr_next;
        err_reg    <= err_next;
        sc_reg     <= sc_next;
        sr_reg     <= sr_next;
        end_c_reg  <= end_c_next;
        end_r_reg  <= end_r_next;
        status_reg <= status_next;
        cell_reg   <= cell_next;
        if (out_load)
        begin
            out_status_reg <= status_reg;
            out_cell_reg   <= cell_reg;
            out_count_reg  <= scan_cnt_reg;
        end
    end

    // sequencer
    always_comb
    begin
        state_next      = state_reg;
        acc_next        = acc_reg;
        pcol_next       = pcol_reg;
        mx_next         = mx_reg;
        my_next         = my_reg;
        robot_col_next  = robot_col_reg;
        robot_row_next  = robot_row_reg;
        pose_valid_next = pose_valid_reg;
        scan_cnt_next   = scan_cnt_reg;
        cur_c_next      = cur_c_reg;
        cur_r_next      = cur_r_reg;
        dc_next         = dc_reg;
        dr_next         = dr_reg;
        err_next        = err_reg;
        sc_next         = sc_reg;
        sr_next         = sr_reg;
        end_c_next      = end_c_reg;
        end_r_next      = end_r_reg;
        status_next     = status_reg;
        cell_next       = cell_reg;
        clr_cnt_next    = clr_cnt_reg;
        clr_reply_next  = clr_reply_reg;
        out_load        = 1'b0;
        out_valid_next  = (out_valid_reg && res_out.ready) ? 1'b0 : out_valid_reg;
        mem_we          = 1'b0;
        mem_wdata       = ogru_pkg::CELL_FREE;
        mem_addr        = {cur_r_reg[7:0], cur_c_reg[7:0]};
        mul_a           = '0;
        mul_b           = '0;
        ecs             = $signed({3'b0, pcol_reg[7:0]});
        ers             = $signed({3'b0, prod_cell[7:0]});
        c0              = $signed({3'b0, robot_col_reg});
        r0              = $signed({3'b0, robot_row_reg});
        dcv             = (ecs > c0) ? ecs - c0 : c0 - ecs;
        drv             = (ers > r0) ? r0 - ers : ers - r0;
        e2              = {err_reg, 1'b0};

        case (state_reg)
            ogru_pkg::S_CLEAR:
            begin
                mem_we       = 1'b1;
                mem_wdata    = ogru_pkg::CELL_UNKNOWN;
                mem_addr     = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 16'd1;
                if (clr_cnt_reg == 16'hFFFF)
                begin
                    clr_reply_next = 1'b0;
                    status_next    = ogru_pkg::STATUS_CLEARED;
                    state_next     = clr_reply_reg ? ogru_pkg::S_DONE : ogru_pkg::S_IDLE;
                end
            end
            ogru_pkg::S_IDLE:
            begin
                if (pt_in.valid)
                begin
                    cell_next = ogru_pkg::CELL_UNKNOWN;
                    if (pt_in.action == ogru_pkg::ACT_POINT)
                    begin
                        if (pt_in.scan_start)
                        begin
                            scan_cnt_next = '0;
                            state_next    = ogru_pkg::S_POSE_X;
                        end
                        else if (!pose_valid_reg)
                        begin
                            status_next = ogru_pkg::STATUS_ROBOT_OUT;
                            state_next  = ogru_pkg::S_DONE;
                        end
                        else
                        begin
                            state_next = ogru_pkg::S_SQ_X;
                        end
                    end
                    else if (pt_in.action == ogru_pkg::ACT_CLEAR)
                    begin
                        clr_cnt_next   = '0;
                        clr_reply_next = 1'b1;
                        state_next     = ogru_pkg::S_CLEAR;
                    end
                    else
                    begin
                        state_next = ogru_pkg::S_READ_RD;
                    end
                end
            end
            ogru_pkg::S_POSE_X:
            begin
                mul_a      = 28'(rx_reg) - 28'(origin_x_reg);
                mul_b      = inv_b;
                state_next = ogru_pkg::S_POSE_Y;
            end
            ogru_pkg::S_POSE_Y:
            begin
                pcol_next  = prod_cell;
                mul_a      = 28'(ry_reg) - 28'(origin_y_reg);
                mul_b      = inv_b;
                state_next = ogru_pkg::S_POSE_CHK;
            end
            ogru_pkg::S_POSE_CHK:
            begin
                if (ogru_pkg::in_grid(pcol_reg, prod_cell, cols_reg, rows_reg))
                begin
                    pose_valid_next = 1'b1;
                    robot_col_next  = pcol_reg[7:0];
                    robot_row_next  = prod_cell[7:0];
                    state_next      = ogru_pkg::S_PFREE_RD;
                end
                else
                begin
                    pose_valid_next = 1'b0;
                    status_next     = ogru_pkg::STATUS_ROBOT_OUT;
                    state_next      = ogru_pkg::S_DONE;
                end
            end
            ogru_pkg::S_PFREE_RD:
            begin
                mem_addr   = {robot_row_reg, robot_col_reg};
                state_next = ogru_pkg::S_PFREE_WR;
            end
            ogru_pkg::S_PFREE_WR:
            begin
                mem_addr   = {robot_row_reg, robot_col_reg};
                mem_we     = (mem_rdata_reg != ogru_pkg::CELL_OCC);
                state_next = ogru_pkg::S_SQ_X;
            end
            ogru_pkg::S_SQ_X:
            begin
                mul_a      = 28'(px_reg);
                mul_b      = 25'(px_reg);
                state_next = ogru_pkg::S_SQ_Y;
            end
            ogru_pkg::S_SQ_Y:
            begin
                acc_next   = prod_reg;
                mul_a      = 28'(py_reg);
                mul_b      = 25'(py_reg);
                state_next = ogru_pkg::S_SQ_CHK;
            end
            ogru_pkg::S_SQ_CHK:
            begin
                if (d2 > $signed({5'd0, range_reg}))
                begin
                    status_next = ogru_pkg::STATUS_RANGE;
                    state_next  = ogru_pkg::S_DONE;
                end
                else
                begin
                    state_next = ogru_pkg::S_ROT1;
                end
            end
            ogru_pkg::S_ROT1:
            begin
                mul_a      = 28'(px_reg);
                mul_b      = 25'(cs_reg);
                state_next = ogru_pkg::S_ROT2;
            end
            ogru_pkg::S_ROT2:
            begin
                acc_next   = prod_reg;
                mul_a      = 28'(py_reg);
                mul_b      = 25'(sn_reg);
                state_next = ogru_pkg::S_ROT3;
            end
            ogru_pkg::S_ROT3:
            begin
                acc_next   = acc_reg - prod_reg;
                mul_a      = 28'(px_reg);
                mul_b      = 25'(sn_reg);
                state_next = ogru_pkg::S_ROT4;
            end
            ogru_pkg::S_ROT4:
            begin
                mx_next    = 28'(rx_reg) + ogru_pkg::pos_t'(acc_reg >>> 14);
                acc_next   = prod_reg;
                mul_a      = 28'(py_reg);
                mul_b      = 25'(cs_reg);
                state_next = ogru_pkg::S_ROT5;
            end
            ogru_pkg::S_ROT5:
            begin
                my_next    = 28'(ry_reg) + ogru_pkg::pos_t'(rot_sum >>> 14);
                mul_a      = mx_reg - 28'(origin_x_reg);
                mul_b      = inv_b;
                state_next = ogru_pkg::S_ROT6;
            end
            ogru_pkg::S_ROT6:
            begin
                pcol_next  = prod_cell;
                mul_a      = my_reg - 28'(origin_y_reg);
                mul_b      = inv_b;
                state_next = ogru_pkg::S_ROT7;
            end
            ogru_pkg::S_ROT7:
            begin
                if (!ogru_pkg::in_grid(pcol_reg, prod_cell, cols_reg, rows_reg))
                begin
                    status_next = ogru_pkg::STATUS_OUTSIDE;
                    state_next  = ogru_pkg::S_DONE;
                end
                else
                begin
                    end_c_next = pcol_reg[7:0];
                    end_r_next = prod_cell[7:0];
                    cur_c_next = c0;
                    cur_r_next = r0;
                    dc_next    = dcv;
                    dr_next    = drv;
                    sc_next    = (c0 < ecs);
                    sr_next    = (r0 < ers);
                    err_next   = dcv + drv;
                    state_next = ogru_pkg::S_WALK_CHK;
                end
            end
            ogru_pkg::S_WALK_CHK:
            begin
                if ((cur_c_reg[7:0] == end_c_reg) && (cur_r_reg[7:0] == end_r_reg)
                    && cur_in)
                begin
                    state_next = ogru_pkg::S_END_RD;
                end
                else
                begin
                    state_next = ogru_pkg::S_WALK_WR;
                end
            end
            ogru_pkg::S_WALK_WR:
            begin
                mem_we = cur_in && (mem_rdata_reg != ogru_pkg::CELL_OCC);
                if ((e2 >= 12'(dr_reg)) && (e2 <= 12'(dc_reg)))
                begin
                    err_next = err_reg + dr_reg + dc_reg;
                end
                else if (e2 >= 12'(dr_reg))
                begin
                    err_next = err_reg + dr_reg;
                end
                else if (e2 <= 12'(dc_reg))
                begin
                    err_next = err_reg + dc_reg;
                end
                if (e2 >= 12'(dr_reg))
                begin
                    cur_c_next = sc_reg ? cur_c_reg + 11'sd1 : cur_c_reg - 11'sd1;
                end
                if (e2 <= 12'(dc_reg))
                begin
                    cur_r_next = sr_reg ? cur_r_reg + 11'sd1 : cur_r_reg - 11'sd1;
                end
                if (ogru_pkg::in_grid(ogru_pkg::pos_t'(cur_c_next), ogru_pkg::pos_t'(cur_r_next),
                                      cols_reg, rows_reg))
                begin
                    state_next = ogru_pkg::S_WALK_CHK;
                end
                else
                begin
                    state_next = ogru_pkg::S_END_RD;
                end
            end
            ogru_pkg::S_END_RD:
            begin
                mem_addr = {end_r_reg, end_c_reg};
                if (in_band)
                begin
                    mem_we        = 1'b1;
                    mem_wdata     = ogru_pkg::CELL_OCC;
                    scan_cnt_next = cnt_inc;
                    status_next   = ogru_pkg::STATUS_ACCEPTED;
                    state_next    = ogru_pkg::S_DONE;
                end
                else
                begin
                    state_next = ogru_pkg::S_END_WR;
                end
            end
            ogru_pkg::S_END_WR:
            begin
                mem_addr      = {end_r_reg, end_c_reg};
                mem_we        = (mem_rdata_reg != ogru_pkg::CELL_OCC);
                scan_cnt_next = cnt_inc;
                status_next   = ogru_pkg::STATUS_ACCEPTED;
                state_next    = ogru_pkg::S_DONE;
            end
            ogru_pkg::S_READ_RD:
            begin
                mem_addr    = {rd_row_reg, rd_col_reg};
                status_next = ogru_pkg::STATUS_READ;
                if (ogru_pkg::in_grid(ogru_pkg::pos_t'({20'd0, rd_col_reg}),
                                      ogru_pkg::pos_t'({20'd0, rd_row_reg}),
                                      cols_reg, rows_reg))
                begin
                    state_next = ogru_pkg::S_READ_WAIT;
                end
                else
                begin
                    state_next = ogru_pkg::S_DONE;
                end
            end
            ogru_pkg::S_READ_WAIT:
            begin
                cell_next  = mem_rdata_reg;
                state_next = ogru_pkg::S_DONE;
            end
            ogru_pkg::S_DONE:
            begin
                if (!out_valid_reg || res_out.ready)
                begin
                    out_load       = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ogru_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = ogru_pkg::S_IDLE;
            end
        endcase
    end

    // grid writes outside the sweep stay inside the grid in use
    `OGRU_ASSERT_NOW(a_write_in_grid,
        mem_we && (state_reg != ogru_pkg::S_CLEAR),
        ogru_pkg::in_grid(ogru_pkg::pos_t'({20'd0, mem_addr[7:0]}),
                          ogru_pkg::pos_t'({20'd0, mem_addr[15:8]}), cols_reg, rows_reg))

    `OGRU_ASSERT_NEXT(a_accept_busy, pt_in.valid && pt_in.ready,
        state_reg != ogru_pkg::S_IDLE)

    `OGRU_ASSERT_NOW(a_count_step, !$stable(scan_cnt_reg),
        (scan_cnt_reg == 16'd0) || (scan_cnt_reg == $past(scan_cnt_reg) + 16'd1))

    `OGRU_ASSERT_NOW(a_load_free, out_load, !out_valid_reg || res_out.ready)

endmodule
